[hw/rtl/rpn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the RPN stack calculator
// Token codes, status codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned DefStackDepth = 128;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_DIV   = 3'd4,
    CMD_MOD   = 3'd5,
    CMD_PRINT = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_ZERODIV = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic       load;      // capture token
    logic       pop_rd;    // issue read of top entry, decrement count
    logic       cap_b;     // capture read data into b
    logic       cap_a;     // capture read data into a
    logic       arith;     // compute add/sub/mul step 1
    logic       mul_fin;   // finish multiply
    logic       div_start; // set up divider
    logic       div_step;  // one divider iteration
    logic       div_fin;   // finish divide/mod
    logic       push_r;    // push result
    logic       push_op;   // push operand
    logic       set_halt;  // zero divisor
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic b_zero;     // divisor zero for the current command
    logic div_done;
  } dp_stat_t;

endpackage : rpn_pkg
`default_nettype wire

[hw/rtl/rpn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_ram: generic single-port RAM
// One write or one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule : rpn_ram
`default_nettype wire

[hw/rtl/rpn_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_dp: calculator datapath
// Stack memory and count, operand registers, multiplier and a restoring
// divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int unsigned StackDepth = 128
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rpn_pkg::dp_cmd_t cmd_i,
  input  wire logic [2:0]       tok_cmd,
  input  wire logic [31:0]      tok_operand,
  output rpn_pkg::dp_stat_t     stat_o,
  output logic [31:0]           a_val,
  output logic [31:0]           r_val,
  output logic                  sat,
  output logic                  under
);
  import rpn_pkg::*;

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  logic [CW-1:0] count;
  logic [2:0]    op;
  logic [31:0]   opnd;
  logic [31:0]   b_reg;
  logic [63:0]   prod;
  logic          q_neg;
  logic [31:0]   rem;      // partial remainder
  logic [47:0]   dvd;      // dividend magnitude bits still to shift in
  logic [47:0]   quo;
  logic [31:0]   dvs;      // divisor magnitude
  logic [5:0]    step;
  logic [5:0]    nsteps;
  logic          count_was_empty;

  // Stack memory
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   rdata;
  logic [31:0]   wdata;

  assign we    = cmd_i.push_r | cmd_i.push_op;
  assign wdata = cmd_i.push_op ? opnd : r_val;
  always_comb begin
    if (we) begin
      addr = count[AW-1:0];
    end else begin
      addr = AW'(count - CW'(1));
    end
  end

  rpn_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign stat_o.full     = (count >= CW'(StackDepth));
  assign stat_o.div_done = (step == nsteps);

  // Divisor check on the fresh b value
  logic [31:0] b_abs;
  assign b_abs = b_reg[31] ? (~b_reg + 32'd1) : b_reg;
  assign stat_o.b_zero = (op == CMD_DIV) ? (b_reg == '0) : (b_abs[31:16] == '0);

  // Wide add/sub result with clamp
  logic [32:0] sum;
  assign sum = (op == CMD_SUB) ? ({a_val[31], a_val} - {b_reg[31], b_reg})
                               : ({a_val[31], a_val} + {b_reg[31], b_reg});

  logic [31:0] a_abs;
  assign a_abs = a_val[31] ? (~a_val + 32'd1) : a_val;

  // Multiply result scaled with truncation toward zero
  logic [63:0] pmag;
  logic [47:0] pq;
  logic        pneg;
  assign pneg = prod[63];
  assign pmag = pneg ? (~prod + 64'd1) : prod;
  assign pq   = pmag[63:16];

  // Divider trial subtract
  logic [32:0] trial;
  logic [32:0] rsh;
  assign rsh   = {rem, dvd[47]};
  assign trial = rsh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd_i.pop_rd && count != '0) begin
        count <= count - CW'(1);
      end else if (we) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op    <= tok_cmd;
      opnd  <= tok_operand;
      sat   <= 1'b0;
      under <= 1'b0;
      a_val <= '0;
      b_reg <= '0;
      r_val <= '0;
    end
    if (cmd_i.pop_rd && count == '0) begin
      under <= 1'b1;
    end
    if (cmd_i.cap_b) begin
      b_reg <= (count_was_empty) ? '0 : rdata;
    end
    if (cmd_i.cap_a) begin
      a_val <= (count_was_empty) ? '0 : rdata;
    end
    if (cmd_i.arith) begin
      unique case (op) inside
        CMD_ADD, CMD_SUB: begin
          if (sum[32] != sum[31]) begin
            sat   <= 1'b1;
            r_val <= sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            r_val <= sum[31:0];
          end
        end
        default: prod <= $signed(a_val) * $signed(b_reg);
      endcase
    end
    if (cmd_i.mul_fin) begin
      if (!pneg && pq > 48'h0000_7FFF_FFFF) begin
        sat <= 1'b1; r_val <= 32'h7FFF_FFFF;
      end else if (pneg && pq > 48'h0000_8000_0000) begin
        sat <= 1'b1; r_val <= 32'h8000_0000;
      end else begin
        r_val <= pneg ? (~pq[31:0] + 32'd1) : pq[31:0];
      end
    end
    if (cmd_i.div_start) begin
      rem  <= '0;
      quo  <= '0;
      step <= '0;
      if (op == CMD_DIV) begin
        q_neg  <= a_val[31] ^ b_reg[31];
        dvd    <= {a_abs, 16'd0};
        dvs    <= b_abs;
        nsteps <= 6'd48;
      end else begin
        q_neg  <= a_val[31];
        dvd    <= {16'd0, a_abs[31:16], 16'd0};
        dvs    <= {16'd0, b_abs[31:16]};
        nsteps <= 6'd32;
      end
    end
    if (cmd_i.div_step) begin
      dvd  <= {dvd[46:0], 1'b0};
      step <= step + 6'd1;
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= rsh[31:0];
        quo <= {quo[46:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      if (op == CMD_DIV) begin
        if (!q_neg && quo > 48'h0000_7FFF_FFFF) begin
          sat <= 1'b1; r_val <= 32'h7FFF_FFFF;
        end else if (q_neg && quo > 48'h0000_8000_0000) begin
          sat <= 1'b1; r_val <= 32'h8000_0000;
        end else begin
          r_val <= q_neg ? (~quo[31:0] + 32'd1) : quo[31:0];
        end
      end else begin
        // remainder is integer, place in Q16.16 with dividend sign
        r_val <= q_neg ? (~{rem[15:0], 16'd0} + 32'd1) : {rem[15:0], 16'd0};
      end
    end
  end

  // Remembers whether the pop hit an empty stack, for the capture next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count_was_empty <= 1'b0;
    end else if (cmd_i.pop_rd) begin
      count_was_empty <= (count == '0);
    end
  end
endmodule : rpn_dp
`default_nettype wire

[hw/rtl/rpn_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_ctrl: calculator controller
// Sequences pops, arithmetic, divider iterations and pushes per token, and
// holds the result transaction until taken.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        cmd,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic                   out_printed,
  output logic                   out_use_a,
  output rpn_pkg::dp_cmd_t       cmd_o,
  input  wire rpn_pkg::dp_stat_t stat_i,
  input  wire logic              under
);
  import rpn_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DEC    = 11'b000_0000_0010,
    S_POPB   = 11'b000_0000_0100,
    S_CHKB   = 11'b000_0000_1000,
    S_POPA   = 11'b000_0001_0000,
    S_ARITH  = 11'b000_0010_0000,
    S_MULF   = 11'b000_0100_0000,
    S_DIV    = 11'b000_1000_0000,
    S_DIVF   = 11'b001_0000_0000,
    S_PUSH   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [2:0] op;
  logic       halted;
  logic [2:0] st_code;

  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmd_o      = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_o.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (halted || op == CMD_NONE) begin
          state_next = S_DONE;
        end else if (op == CMD_PUSH) begin
          cmd_o.push_op = !stat_i.full;
          state_next    = S_DONE;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_next   = S_POPB;
        end
      end
      S_POPB: begin
        if (op == CMD_PRINT) begin
          cmd_o.cap_a = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd_o.cap_b = 1'b1;
          state_next  = S_CHKB;
        end
      end
      S_CHKB: begin
        if ((op == CMD_DIV || op == CMD_MOD) && stat_i.b_zero) begin
          cmd_o.set_halt = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_next   = S_POPA;
        end
      end
      S_POPA: begin
        cmd_o.cap_a = 1'b1;
        state_next  = S_ARITH;
      end
      S_ARITH: begin
        if (op == CMD_DIV || op == CMD_MOD) begin
          cmd_o.div_start = 1'b1;
          state_next      = S_DIV;
        end else begin
          cmd_o.arith = 1'b1;
          state_next  = (op == CMD_MUL) ? S_MULF : S_PUSH;
        end
      end
      S_MULF: begin
        cmd_o.mul_fin = 1'b1;
        state_next    = S_PUSH;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_fin = 1'b1;
          state_next    = S_PUSH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_PUSH: begin
        cmd_o.push_r = !stat_i.full;
        state_next   = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_o.set_halt) begin
        halted <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end else if (state == S_DONE) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Token bookkeeping and status
  always_ff @(posedge clk) begin
    if (cmd_o.load) begin
      op          <= cmd;
      st_code     <= ST_OK;
      out_printed <= 1'b0;
      out_use_a   <= 1'b0;
    end
    if (state == S_DEC) begin
      if (halted) begin
        st_code <= ST_HALTED;
      end else if (op == CMD_PUSH && stat_i.full) begin
        st_code <= ST_OVER;
      end else if (op == CMD_PRINT) begin
        out_printed <= 1'b1;
        out_use_a   <= 1'b1;
      end
    end
    if (cmd_o.set_halt) begin
      st_code <= ST_ZERODIV;
    end
  end

  assign out_status = (st_code == ST_OK && under) ? ST_UNDER : st_code;
endmodule : rpn_ctrl
`default_nettype wire

[hw/rtl/rpn_stack_calculator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse-Polish calculator on a Q16.16 stack
// Controller sequences a datapath holding the operand stack RAM.
// ----------------------------------------------------------------------------
// channel | signals                                    | direction
// in      | in_valid, in_stall, cmd, operand           | host to block
// out     | out_valid, out_stall, result_value, printed, | block to host
//         | status, saturated                          |
// Push, unknown and halted tokens go straight from decode to done; mod and div
// run the divider, which retires one quotient bit a cycle (32 and 48 steps).
// The stack RAM has one port, so each pop needs its own read of the RAM.
// Reset clears the count and the halt flag; stack contents need no clearing.
// A result waits in the output register while out_stall is high; no new
// token is taken until it has gone, at the earliest the cycle after.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::DefStackDepth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] operand,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      result_value,
  output logic                    printed,
  output logic [2:0]              status,
  output logic                    saturated
);
  import rpn_pkg::*;

  dp_cmd_t     dcmd;
  dp_stat_t    dstat;
  logic [31:0] a_val, r_val;
  logic        sat, under, use_a;

  rpn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .out_stall(out_stall), .out_valid(out_valid), .out_status(status),
    .out_printed(printed), .out_use_a(use_a), .cmd_o(dcmd), .stat_i(dstat),
    .under(under)
  );

  rpn_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd_i(dcmd), .tok_cmd(cmd), .tok_operand(operand),
    .stat_o(dstat), .a_val(a_val), .r_val(r_val), .sat(sat), .under(under)
  );

  // Only print shows a value; saturation only for executed arithmetic
  assign result_value = use_a ? $signed(a_val) : 32'sd0;
  assign saturated    = sat && (status != ST_HALTED) && (status != ST_ZERODIV);
endmodule : rpn_stack_calculator
`default_nettype wire
